[hdl/imc_pkg.sv]
// ----------------------------------------------------------------------------
// imc_pkg
// Shared types and constants of the motion classifier: register indexes,
// class codes, LED codes and the fixed-point tilt threshold.
// ----------------------------------------------------------------------------
package imc_pkg;

   localparam int LIMIT_WIDTH = 34;

   // 0.985^2 as 63585/65536; the tilt test is folded to
   // (65536-63585)*|a|^2 < 65536*(ax^2+ay^2)
   localparam int TILT_NUM   = 63585;
   localparam int TILT_SHIFT = 16;
   localparam int TILT_DEN   = 65536;
   localparam int TILT_GAP   = TILT_DEN - TILT_NUM;

   localparam int RST_ACCEL_OFFSET_X = 1029;
   localparam int RST_ACCEL_OFFSET_Y = -606;
   localparam int RST_GYRO_OFFSET_X  = -96;
   localparam int RST_GYRO_OFFSET_Y  = 15;
   localparam int RST_GYRO_OFFSET_Z  = 36;
   localparam logic [LIMIT_WIDTH-1:0] RST_ROTATION_LIMIT_SQ    = 34'd18688329;
   localparam logic [LIMIT_WIDTH-1:0] RST_GRAVITY_BAND_LOW_SQ  = 34'd269855532;
   localparam logic [LIMIT_WIDTH-1:0] RST_GRAVITY_BAND_HIGH_SQ = 34'd301862772;

   typedef enum logic [2:0] {
      REG_ACCEL_OFFSET_X       = 3'd0,
      REG_ACCEL_OFFSET_Y       = 3'd1,
      REG_GYRO_OFFSET_X        = 3'd2,
      REG_GYRO_OFFSET_Y        = 3'd3,
      REG_GYRO_OFFSET_Z        = 3'd4,
      REG_ROTATION_LIMIT_SQ    = 3'd5,
      REG_GRAVITY_BAND_LOW_SQ  = 3'd6,
      REG_GRAVITY_BAND_HIGH_SQ = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MOTION_STATIONARY = 2'd0,
      MOTION_TILTED     = 2'd1,
      MOTION_ROTATING   = 2'd2,
      MOTION_MOVING     = 2'd3
   } motion_class_type;

   localparam logic [2:0] LED_OFF   = 3'b000;
   localparam logic [2:0] LED_RED   = 3'b001;
   localparam logic [2:0] LED_GREEN = 3'b010;
   localparam logic [2:0] LED_BLUE  = 3'b100;

endpackage

[hdl/imu_motion_classifier_unit.sv]
// Throughput: one sample per cycle while rsp_ready takes each beat, through a
// five-stage pipeline (offset/abs, square, sum, compare/scale, tilt compare);
// stages advance whenever the next slot is free or emptying.
// Reset (synchronous): empties all stages and restores register defaults.
// ----------------------------------------------------------------------------
// imu_motion_classifier_unit
// Six-axis motion classifier: offset removal, squared magnitudes and
// priority threshold tests giving a motion class and LED code.
// ----------------------------------------------------------------------------
module imu_motion_classifier_unit #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int CSR_WIDTH    = (SAMPLE_WIDTH > imc_pkg::LIMIT_WIDTH) ?
                                SAMPLE_WIDTH : imc_pkg::LIMIT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_write_enable,
   input  logic [2:0]                     csr_index,
   input  logic [CSR_WIDTH-1:0]           csr_wdata,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0] req_gyro_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_gyro_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_gyro_z,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_motion_class,
   output logic [2:0]                     rsp_led_rgb
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int AXES = 6;
   localparam int SQW  = 2 * SW;
   localparam int XYW  = SQW + 1;
   localparam int SUMW = SQW + 2;
   localparam int CW   = (SUMW > imc_pkg::LIMIT_WIDTH) ? SUMW : imc_pkg::LIMIT_WIDTH;
   localparam int PW   = SUMW + imc_pkg::TILT_SHIFT;
   localparam int LW   = imc_pkg::LIMIT_WIDTH;

   // configuration registers
   logic signed [SW-1:0] accel_offset_x_ff, accel_offset_y_ff;
   logic signed [SW-1:0] gyro_offset_x_ff, gyro_offset_y_ff, gyro_offset_z_ff;
   logic [LW-1:0]        rotation_limit_sq_ff, band_low_sq_ff, band_high_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_offset_x_ff    <= SW'(imc_pkg::RST_ACCEL_OFFSET_X);
         accel_offset_y_ff    <= SW'(imc_pkg::RST_ACCEL_OFFSET_Y);
         gyro_offset_x_ff     <= SW'(imc_pkg::RST_GYRO_OFFSET_X);
         gyro_offset_y_ff     <= SW'(imc_pkg::RST_GYRO_OFFSET_Y);
         gyro_offset_z_ff     <= SW'(imc_pkg::RST_GYRO_OFFSET_Z);
         rotation_limit_sq_ff <= imc_pkg::RST_ROTATION_LIMIT_SQ;
         band_low_sq_ff       <= imc_pkg::RST_GRAVITY_BAND_LOW_SQ;
         band_high_sq_ff      <= imc_pkg::RST_GRAVITY_BAND_HIGH_SQ;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            imc_pkg::REG_ACCEL_OFFSET_X:       accel_offset_x_ff <= csr_wdata[SW-1:0];
            imc_pkg::REG_ACCEL_OFFSET_Y:       accel_offset_y_ff <= csr_wdata[SW-1:0];
            imc_pkg::REG_GYRO_OFFSET_X:        gyro_offset_x_ff  <= csr_wdata[SW-1:0];
            imc_pkg::REG_GYRO_OFFSET_Y:        gyro_offset_y_ff  <= csr_wdata[SW-1:0];
            imc_pkg::REG_GYRO_OFFSET_Z:        gyro_offset_z_ff  <= csr_wdata[SW-1:0];
            imc_pkg::REG_ROTATION_LIMIT_SQ:    rotation_limit_sq_ff <= csr_wdata[LW-1:0];
            imc_pkg::REG_GRAVITY_BAND_LOW_SQ:  band_low_sq_ff    <= csr_wdata[LW-1:0];
            imc_pkg::REG_GRAVITY_BAND_HIGH_SQ: band_high_sq_ff   <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when it is empty or its beat moves on
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic en1, en2, en3, en4, en5;

   assign en5       = !s5_valid_ff || rsp_ready;
   assign en4       = !s4_valid_ff || en5;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage 1: offset removal and magnitude
   logic signed [SW-1:0] raw [AXES];
   logic signed [SW-1:0] off [AXES];
   logic [SW-1:0]        s1_abs_in [AXES];
   logic [SW-1:0]        s1_abs_ff [AXES];

   assign raw[0] = req_accel_x;
   assign raw[1] = req_accel_y;
   assign raw[2] = req_accel_z;
   assign raw[3] = req_gyro_x;
   assign raw[4] = req_gyro_y;
   assign raw[5] = req_gyro_z;
   assign off[0] = accel_offset_x_ff;
   assign off[1] = accel_offset_y_ff;
   assign off[2] = '0;
   assign off[3] = gyro_offset_x_ff;
   assign off[4] = gyro_offset_y_ff;
   assign off[5] = gyro_offset_z_ff;

   always_comb begin
      logic [SW:0] diff;
      for (int i = 0; i < AXES; i++) begin
         diff = {raw[i][SW-1], raw[i]} - {off[i][SW-1], off[i]};
         // |diff| never exceeds 2^SW - 1
         s1_abs_in[i] = diff[SW] ? SW'(~diff + 1'b1) : diff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_abs_ff <= s1_abs_in;
   end

   // stage 2: squares
   logic [SQW-1:0] s2_sq_ff [AXES];

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int i = 0; i < AXES; i++) begin
            s2_sq_ff[i] <= SQW'(s1_abs_ff[i]) * SQW'(s1_abs_ff[i]);
         end
      end
   end

   // stage 3: squared magnitudes
   logic [XYW-1:0]  s3_axy_in, s3_axy_ff;
   logic [SUMW-1:0] s3_acc_ff, s3_gyr_ff;

   assign s3_axy_in = XYW'(s2_sq_ff[0]) + XYW'(s2_sq_ff[1]);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_axy_ff <= s3_axy_in;
         s3_acc_ff <= SUMW'(s3_axy_in) + SUMW'(s2_sq_ff[2]);
         s3_gyr_ff <= SUMW'(s2_sq_ff[3]) + SUMW'(s2_sq_ff[4]) + SUMW'(s2_sq_ff[5]);
      end
   end

   // stage 4: threshold compares and tilt scaling
   logic          s4_rot_ff, s4_mov_ff;
   logic [PW-1:0] s4_prod_ff, s4_ref_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_rot_ff  <= CW'(s3_gyr_ff) > CW'(rotation_limit_sq_ff);
         s4_mov_ff  <= (CW'(s3_acc_ff) < CW'(band_low_sq_ff)) ||
                       (CW'(s3_acc_ff) > CW'(band_high_sq_ff));
         s4_prod_ff <= PW'(s3_acc_ff) * PW'(imc_pkg::TILT_GAP);
         s4_ref_ff  <= PW'(s3_axy_ff) << imc_pkg::TILT_SHIFT;
      end
   end

   // stage 5: class and LED, held until taken
   imc_pkg::motion_class_type s5_class_in, s5_class_ff;
   logic [2:0]                s5_led_in, s5_led_ff;

   always_comb begin
      priority if (s4_rot_ff) begin
         s5_class_in = imc_pkg::MOTION_ROTATING;
         s5_led_in   = imc_pkg::LED_BLUE;
      end else if (s4_mov_ff) begin
         s5_class_in = imc_pkg::MOTION_MOVING;
         s5_led_in   = imc_pkg::LED_GREEN;
      end else if (s4_prod_ff < s4_ref_ff) begin
         s5_class_in = imc_pkg::MOTION_TILTED;
         s5_led_in   = imc_pkg::LED_RED;
      end else begin
         s5_class_in = imc_pkg::MOTION_STATIONARY;
         s5_led_in   = imc_pkg::LED_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_class_ff <= s5_class_in;
         s5_led_ff   <= s5_led_in;
      end
   end

   assign rsp_valid        = s5_valid_ff;
   assign rsp_motion_class = s5_class_ff;
   assign rsp_led_rgb      = s5_led_ff;

   // checks
   a_led_matches_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_motion_class == imc_pkg::MOTION_ROTATING   && rsp_led_rgb == imc_pkg::LED_BLUE)  ||
         (rsp_motion_class == imc_pkg::MOTION_MOVING     && rsp_led_rgb == imc_pkg::LED_GREEN) ||
         (rsp_motion_class == imc_pkg::MOTION_TILTED     && rsp_led_rgb == imc_pkg::LED_RED)   ||
         (rsp_motion_class == imc_pkg::MOTION_STATIONARY && rsp_led_rgb == imc_pkg::LED_OFF))
      else $error("LED code does not match motion class");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("req_ready low with an empty first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !en5 |=> s4_valid_ff && $stable(s4_prod_ff) && $stable(s4_rot_ff))
      else $error("stalled beat in stage 4 lost or changed");

   a_rotation_wins: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && en5 && s4_rot_ff |=>
         rsp_valid && rsp_motion_class == imc_pkg::MOTION_ROTATING)
      else $error("rotation not given priority");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

[dv/imu_motion_classifier_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_motion_classifier_unit_test
// Drives raw six-axis samples into the classifier across several register
// settings and handshake idling patterns. A scoreboard works out the motion
// class and LED code of every accepted sample and checks the rsp beats in
// order.
// ----------------------------------------------------------------------------
module imu_motion_classifier_unit_test;

   localparam int SW              = 16;
   localparam int CSR_W           = imc_pkg::LIMIT_WIDTH;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam logic signed [SW-1:0] S_MIN = 16'sh8000;
   localparam logic signed [SW-1:0] S_MAX = 16'sh7FFF;

   typedef struct {
      logic signed [SW-1:0] accel_x;
      logic signed [SW-1:0] accel_y;
      logic signed [SW-1:0] accel_z;
      logic signed [SW-1:0] gyro_x;
      logic signed [SW-1:0] gyro_y;
      logic signed [SW-1:0] gyro_z;
   } imu_sample_type;

   typedef struct {
      imc_pkg::motion_class_type motion_class;
      logic [2:0]                led_rgb;
   } motion_result_type;

   class motion_scoreboard;
      logic signed [SW-1:0] accel_off_x, accel_off_y;
      logic signed [SW-1:0] gyro_off_x, gyro_off_y, gyro_off_z;
      logic [CSR_W-1:0]     rotation_limit, band_low, band_high;
      motion_result_type    expected_motion[$];
      int                   failures;

      function new();
         accel_off_x    = SW'(imc_pkg::RST_ACCEL_OFFSET_X);
         accel_off_y    = SW'(imc_pkg::RST_ACCEL_OFFSET_Y);
         gyro_off_x     = SW'(imc_pkg::RST_GYRO_OFFSET_X);
         gyro_off_y     = SW'(imc_pkg::RST_GYRO_OFFSET_Y);
         gyro_off_z     = SW'(imc_pkg::RST_GYRO_OFFSET_Z);
         rotation_limit = imc_pkg::RST_ROTATION_LIMIT_SQ;
         band_low       = imc_pkg::RST_GRAVITY_BAND_LOW_SQ;
         band_high      = imc_pkg::RST_GRAVITY_BAND_HIGH_SQ;
         failures       = 0;
      endfunction

      function void write_register(imc_pkg::csr_index_type idx, logic [CSR_W-1:0] data);
         unique case (idx)
            imc_pkg::REG_ACCEL_OFFSET_X:       accel_off_x    = data[SW-1:0];
            imc_pkg::REG_ACCEL_OFFSET_Y:       accel_off_y    = data[SW-1:0];
            imc_pkg::REG_GYRO_OFFSET_X:        gyro_off_x     = data[SW-1:0];
            imc_pkg::REG_GYRO_OFFSET_Y:        gyro_off_y     = data[SW-1:0];
            imc_pkg::REG_GYRO_OFFSET_Z:        gyro_off_z     = data[SW-1:0];
            imc_pkg::REG_ROTATION_LIMIT_SQ:    rotation_limit = data;
            imc_pkg::REG_GRAVITY_BAND_LOW_SQ:  band_low       = data;
            imc_pkg::REG_GRAVITY_BAND_HIGH_SQ: band_high      = data;
            default: ;
         endcase
      endfunction

      static function logic [63:0] square_diff(logic signed [SW-1:0] raw,
                                               logic signed [SW-1:0] off);
         longint d;
         d = longint'(raw) - longint'(off);
         if (d < 0) d = -d;
         return d * d;
      endfunction

      function void note_sample(imu_sample_type s);
         logic [63:0]       az_sq, accel_sq, gyro_sq;
         motion_result_type r;
         az_sq    = square_diff(s.accel_z, '0);
         accel_sq = square_diff(s.accel_x, accel_off_x) +
                    square_diff(s.accel_y, accel_off_y) + az_sq;
         gyro_sq  = square_diff(s.gyro_x, gyro_off_x) +
                    square_diff(s.gyro_y, gyro_off_y) +
                    square_diff(s.gyro_z, gyro_off_z);
         if (gyro_sq > rotation_limit) begin
            r.motion_class = imc_pkg::MOTION_ROTATING;
            r.led_rgb      = imc_pkg::LED_BLUE;
         end else if (accel_sq < band_low || accel_sq > band_high) begin
            r.motion_class = imc_pkg::MOTION_MOVING;
            r.led_rgb      = imc_pkg::LED_GREEN;
         end else if (az_sq * imc_pkg::TILT_DEN < accel_sq * imc_pkg::TILT_NUM) begin
            r.motion_class = imc_pkg::MOTION_TILTED;
            r.led_rgb      = imc_pkg::LED_RED;
         end else begin
            r.motion_class = imc_pkg::MOTION_STATIONARY;
            r.led_rgb      = imc_pkg::LED_OFF;
         end
         expected_motion.push_back(r);
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
      endfunction

      function void check_result(logic [1:0] got_class, logic [2:0] got_led);
         motion_result_type want;
         if (expected_motion.size() == 0) begin
            flag($sformatf("rsp beat with nothing pending: class %0d led %0d",
                           got_class, got_led));
            return;
         end
         want = expected_motion.pop_front();
         if (got_class !== want.motion_class)
            flag($sformatf("motion_class expected %0d got %0d", want.motion_class, got_class));
         if (got_led !== want.led_rgb)
            flag($sformatf("led_rgb expected %0d got %0d", want.led_rgb, got_led));
      endfunction
   endclass

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [2:0]              csr_index        = '0;
   logic [CSR_W-1:0]        csr_wdata        = '0;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic signed [SW-1:0]    req_accel_x      = '0;
   logic signed [SW-1:0]    req_accel_y      = '0;
   logic signed [SW-1:0]    req_accel_z      = '0;
   logic signed [SW-1:0]    req_gyro_x       = '0;
   logic signed [SW-1:0]    req_gyro_y       = '0;
   logic signed [SW-1:0]    req_gyro_z       = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic [1:0]              rsp_motion_class;
   logic [2:0]              rsp_led_rgb;

   motion_scoreboard board = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_until    = 0;
   int negedge_count = 0;
   int quiet_cycles  = 0;

   imu_motion_classifier_unit dut (.*);

   always #6 clock = ~clock;

   always @(negedge clock) begin
      negedge_count <= negedge_count + 1;
      if (negedge_count < hold_until) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_motion_class, rsp_led_rgb);
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [SW-1:0] wrap16(logic [31:0] v);
      return v[SW-1:0];
   endfunction

   function automatic int noise(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic real frac();
      return real'($urandom_range(0, 1000000)) / 1.0e6;
   endfunction

   // deltas are taken relative to the current calibration offsets
   function automatic imu_sample_type from_deltas(int ax, int ay, int az,
                                                  int gx, int gy, int gz);
      imu_sample_type s;
      s.accel_x = wrap16(ax + board.accel_off_x);
      s.accel_y = wrap16(ay + board.accel_off_y);
      s.accel_z = wrap16(az);
      s.gyro_x  = wrap16(gx + board.gyro_off_x);
      s.gyro_y  = wrap16(gy + board.gyro_off_y);
      s.gyro_z  = wrap16(gz + board.gyro_off_z);
      return s;
   endfunction

   function automatic imu_sample_type uniform_sample(logic signed [SW-1:0] a,
                                                     logic signed [SW-1:0] g);
      imu_sample_type s;
      s.accel_x = a;
      s.accel_y = a;
      s.accel_z = a;
      s.gyro_x  = g;
      s.gyro_y  = g;
      s.gyro_z  = g;
      return s;
   endfunction

   function automatic logic signed [SW-1:0] corner_value(logic signed [SW-1:0] centre);
      unique case ($urandom_range(0, 4))
         0: return S_MIN;
         1: return S_MAX;
         2: return '0;
         3: return -16'sd1;
         default: return centre;
      endcase
   endfunction

   function automatic imu_sample_type make_sample();
      imu_sample_type s;
      int  pick, root, az_mid;
      int  gd[3];
      real lo, hi, mag, tilt, turn;
      lo = real'(board.band_low);
      hi = real'(board.band_high);
      if (hi > 9.0e8) hi = 9.0e8;
      if (hi < lo) hi = lo;
      az_mid = int'($sqrt((lo + hi) / 2.0));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         s.accel_x = wrap16($urandom);
         s.accel_y = wrap16($urandom);
         s.accel_z = wrap16($urandom);
         s.gyro_x  = wrap16($urandom);
         s.gyro_y  = wrap16($urandom);
         s.gyro_z  = wrap16($urandom);
      end else if (pick < 14) begin
         s.accel_x = corner_value(board.accel_off_x);
         s.accel_y = corner_value(board.accel_off_y);
         s.accel_z = corner_value('0);
         s.gyro_x  = corner_value(board.gyro_off_x);
         s.gyro_y  = corner_value(board.gyro_off_y);
         s.gyro_z  = corner_value(board.gyro_off_z);
      end else if (pick < 18) begin
         // accel vector of zero length
         s = from_deltas(0, 0, 0, noise(200), noise(200), noise(200));
      end else if (pick < 24) begin
         gd = '{0, 0, 0};
         root = int'($floor($sqrt(real'(board.rotation_limit))));
         gd[$urandom_range(0, 2)] = root + int'($urandom_range(0, 1));
         s = from_deltas(0, 0, az_mid, gd[0], gd[1], gd[2]);
      end else if (pick < 30) begin
         if ($urandom_range(0, 1)) root = int'($floor($sqrt(real'(board.band_low))));
         else root = int'($floor($sqrt(real'(board.band_high))));
         s = from_deltas(0, 0, root + int'($urandom_range(0, 2)) - 1, 0, 0, 0);
      end else begin
         if ($urandom_range(0, 3) == 0) mag = 8000.0 + 16000.0 * frac();
         else mag = $sqrt(lo + (hi - lo) * frac());
         tilt = 0.35 * frac();
         turn = 6.2832 * frac();
         root = ($urandom_range(0, 9) < 7) ? 1500 : 6000;
         s = from_deltas(int'(mag * $sin(tilt) * $cos(turn)),
                         int'(mag * $sin(tilt) * $sin(turn)),
                         int'(mag * $cos(tilt)) * (($urandom_range(0, 4) == 0) ? -1 : 1),
                         noise(root), noise(root), noise(root));
      end
      return s;
   endfunction

   task automatic send_sample(input imu_sample_type s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= s.accel_x;
      req_accel_y <= s.accel_y;
      req_accel_z <= s.accel_z;
      req_gyro_x  <= s.gyro_x;
      req_gyro_y  <= s.gyro_y;
      req_gyro_z  <= s.gyro_z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(s);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_motion.size() != 0) @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_W-1:0] ax_off, ay_off, gx_off, gy_off, gz_off,
                            input logic [CSR_W-1:0] rot_limit, low_sq, high_sq);
      logic [CSR_W-1:0] values [8];
      values = '{ax_off, ay_off, gx_off, gy_off, gz_off, rot_limit, low_sq, high_sq};
      for (int i = 0; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= imc_pkg::csr_index_type'(i);
         csr_wdata        <= values[i];
         @(posedge clock);
         board.write_register(imc_pkg::csr_index_type'(i), values[i]);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // random upper bits check that only the low field bits are kept
   function automatic logic [CSR_W-1:0] random_offset();
      logic [CSR_W-1:0] v;
      v = CSR_W'({$urandom, $urandom});
      v[SW-1:0] = wrap16(noise(3000));
      return v;
   endfunction

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                            input int hold);
      @(posedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      hold_until    = negedge_count + hold;
      @(negedge clock);
      repeat (count) send_sample(make_sample());
      drain();
   endtask

   initial begin : stimulus
      imu_sample_type directed[$];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(uniform_sample('0, '0));
      directed.push_back(from_deltas(0, 0, 0, 0, 0, 0));
      directed.push_back(from_deltas(0, 0, 16900, 0, 0, 0));
      directed.push_back(from_deltas(0, 0, -16900, 0, 0, 0));
      directed.push_back(from_deltas(4000, 0, 16000, 0, 0, 0));
      directed.push_back(from_deltas(0, -4000, 16000, 0, 0, 0));
      directed.push_back(from_deltas(16000, 0, 0, 0, 0, 0));
      directed.push_back(from_deltas(2900, 0, 16700, 0, 0, 0));
      directed.push_back(from_deltas(2950, 0, 16700, 0, 0, 0));
      directed.push_back(from_deltas(0, 0, 16900, 4323, 0, 0));
      directed.push_back(from_deltas(0, 0, 16900, 4324, 0, 0));
      directed.push_back(from_deltas(0, 0, 16900, 0, 4324, 0));
      directed.push_back(from_deltas(0, 0, 16900, 0, 0, -4324));
      directed.push_back(from_deltas(0, 0, 20000, 0, 0, 0));
      directed.push_back(from_deltas(0, 0, 10000, 0, 0, 0));
      directed.push_back(uniform_sample(S_MIN, S_MIN));
      directed.push_back(uniform_sample(S_MAX, S_MAX));
      directed.push_back(uniform_sample(S_MAX, S_MIN));
      directed.push_back(uniform_sample(S_MIN, S_MAX));
      directed.push_back(uniform_sample(16'sh5555, -16'sh5556));
      foreach (directed[i]) send_sample(directed[i]);
      drain();

      // long rsp hold-off while samples keep coming, to back the pipeline up
      run_phase(400, 0, 0, 300);

      configure(random_offset(), random_offset(), random_offset(), random_offset(),
                random_offset(), 34'd9000000, 34'd256000000, 34'd306250000);
      run_phase(450, 77, 0, 0);

      configure(34'h7FFF, 34'h7FFF, 34'h7FFF, 34'h7FFF, 34'h7FFF, '1, '0, '1);
      run_phase(300, 0, 77, 0);

      // inverted gravity band, zero rotation limit
      configure(34'h3FFFF8000, 34'h3FFFF8000, 34'h3FFFF8000, 34'h3FFFF8000, 34'h3FFFF8000,
                '0, '1, '0);
      run_phase(120, 14, 14, 0);

      configure(CSR_W'(imc_pkg::RST_ACCEL_OFFSET_X), CSR_W'(imc_pkg::RST_ACCEL_OFFSET_Y),
                CSR_W'(imc_pkg::RST_GYRO_OFFSET_X), CSR_W'(imc_pkg::RST_GYRO_OFFSET_Y),
                CSR_W'(imc_pkg::RST_GYRO_OFFSET_Z), imc_pkg::RST_ROTATION_LIMIT_SQ,
                imc_pkg::RST_GRAVITY_BAND_LOW_SQ, imc_pkg::RST_GRAVITY_BAND_HIGH_SQ);
      run_phase(330, 14, 14, 0);

      repeat (10) @(posedge clock);
      if (board.failures == 0 && board.expected_motion.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
